// File: rtl/core/interval_jitter_monitor_assert.svh
// Assertion macros used by the checker file of the interval jitter monitor.
// No dependencies; included by bare file name.
`ifndef INTERVAL_JITTER_MONITOR_ASSERT_SVH
`define INTERVAL_JITTER_MONITOR_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define IJM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked check that also holds during reset.
`define IJM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

// File: rtl/core/ijm_pkg.sv
// Shared types and constants of the interval jitter monitor.
// No dependencies; used by scoped names in the top, ctrl, datapath and checker.
`timescale 1ns / 1ps

package ijm_pkg;

  localparam int unsigned THR_W      = 24;
  localparam logic [THR_W-1:0] THR_RESET = 24'd500;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned SAMPLES_W  = 7;
  localparam int unsigned FRAC_W     = 8;   // Q.8 outputs
  localparam int unsigned VAR_FRAC_W = 16;  // variance carried with 16 fraction bits
  localparam int unsigned SQRT_IN_W  = 64;
  localparam int unsigned SQRT_OUT_W = 32;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_ACC  = 10'b0000001000,
    S_PROD = 10'b0000010000,
    S_DIFF = 10'b0000100000,
    S_DST  = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_SQRT = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_old;
    logic mul;
    logic acc;
    logic prod;
    logic diff;
    logic div_start;
    logic sqrt_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic result_ok;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/interval_jitter_monitor.sv
// Top level of the interval jitter monitor: sequencer plus datapath.
// Depends on ijm_pkg, ijm_ctrl, ijm_datapath (and through it ijm_ram, ijm_divider).
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / arrival_time_us_i): one microsecond
//   arrival timestamp per transaction. The first one after reset only primes the
//   block; later ones form an interval to the previous timestamp (wrapping), which
//   is clamped to 2^INTERVAL_WIDTH-1 and entered into a window of WINDOW intervals.
//   Output channel (out_valid_o / out_ready_i): one result per timestamp once two
//   or more intervals are held: mean and population standard deviation in Q.8,
//   threshold flag, sample count and clamp flag.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): jitter threshold in
//   whole microseconds, always ready; write it only while the block is idle.
// Sequencing
//   Priming transactions finish in S_IDLE; the one-interval case goes back to idle
//   after S_RD, S_MUL and S_ACC. A result also runs S_PROD, S_DIFF, S_DST, the
//   bit-serial variance divider (2*IW + 2*ceil(log2(WINDOW+1)) + 16 steps, 78 at
//   defaults) and the 32-step square root; the mean divider runs alongside.
//   One item is in flight at a time; in_ready_o is high while the sequencer idles.
// Reset and stall
//   Reset clears the interval history, sums and pending result; the threshold
//   returns to 500. A finished result sits in the output register; the next
//   timestamp is accepted meanwhile, and its result waits until that slot frees.
module interval_jitter_monitor #(
  parameter int unsigned WINDOW          = 100,
  parameter int unsigned INTERVAL_WIDTH  = 24,
  parameter int unsigned TIMESTAMP_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [TIMESTAMP_WIDTH-1:0]    arrival_time_us_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ijm_pkg::THR_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ijm_pkg::OUT_W-1:0]     mean_interval_q8_o,
  output logic [ijm_pkg::OUT_W-1:0]     jitter_q8_o,
  output logic                          jitter_exceeded_o,
  output logic [ijm_pkg::SAMPLES_W-1:0] samples_in_window_o,
  output logic                          interval_saturated_o
);

  ijm_pkg::cmd_t    cmd;
  ijm_pkg::status_t status;

  // threshold register never stalls a write
  assign cfg_ready_o = 1'b1;

  ijm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ijm_datapath #(
    .WINDOW          (WINDOW),
    .INTERVAL_WIDTH  (INTERVAL_WIDTH),
    .TIMESTAMP_WIDTH (TIMESTAMP_WIDTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .arrival_time_us_i    (arrival_time_us_i),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .mean_interval_q8_o   (mean_interval_q8_o),
    .jitter_q8_o          (jitter_q8_o),
    .jitter_exceeded_o    (jitter_exceeded_o),
    .samples_in_window_o  (samples_in_window_o),
    .interval_saturated_o (interval_saturated_o)
  );

endmodule

// File: rtl/core/ijm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ijm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/ijm_divider.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module ijm_divider #(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/ijm_ctrl.sv
// Sequencer of the interval jitter monitor: one-hot state machine.
// Depends on ijm_pkg.
`timescale 1ns / 1ps

module ijm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ijm_pkg::status_t status_i,
  output ijm_pkg::cmd_t    cmd_o
);

  ijm_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_ready_o = state_q == ijm_pkg::S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ijm_pkg::S_IDLE: begin
        cmd_o.accept = accept;
        if (accept && status_i.primed) begin
          state_d = ijm_pkg::S_RD;
        end
      end
      ijm_pkg::S_RD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = ijm_pkg::S_MUL;
      end
      ijm_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ijm_pkg::S_ACC;
      end
      ijm_pkg::S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.result_ok ? ijm_pkg::S_PROD : ijm_pkg::S_IDLE;
      end
      ijm_pkg::S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ijm_pkg::S_DIFF;
      end
      ijm_pkg::S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ijm_pkg::S_DST;
      end
      ijm_pkg::S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = ijm_pkg::S_DIV;
      end
      ijm_pkg::S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = ijm_pkg::S_SQRT;
        end
      end
      ijm_pkg::S_SQRT: begin
        if (!status_i.sqrt_busy) begin
          state_d = ijm_pkg::S_DONE;
        end
      end
      ijm_pkg::S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ijm_pkg::S_IDLE;
        end
      end
      default: state_d = ijm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ijm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/ijm_datapath.sv
// Datapath: interval capture, window RAM, running sums, dividers, square root,
// output register. Depends on ijm_pkg, ijm_ram, ijm_divider.
`timescale 1ns / 1ps

module ijm_datapath #(
  parameter int unsigned WINDOW          = 100,
  parameter int unsigned INTERVAL_WIDTH  = 24,
  parameter int unsigned TIMESTAMP_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ijm_pkg::cmd_t                 cmd_i,
  output ijm_pkg::status_t              status_o,
  input  logic [TIMESTAMP_WIDTH-1:0]    arrival_time_us_i,
  input  logic                          cfg_we_i,
  input  logic [ijm_pkg::THR_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ijm_pkg::OUT_W-1:0]     mean_interval_q8_o,
  output logic [ijm_pkg::OUT_W-1:0]     jitter_q8_o,
  output logic                          jitter_exceeded_o,
  output logic [ijm_pkg::SAMPLES_W-1:0] samples_in_window_o,
  output logic                          interval_saturated_o
);

  localparam int unsigned IW     = INTERVAL_WIDTH;
  localparam int unsigned TW     = TIMESTAMP_WIDTH;
  localparam int unsigned AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NCW    = $clog2(WINDOW + 1);
  localparam int unsigned EXT_W  = (TW > IW) ? TW : IW + 1;
  localparam int unsigned SUM_W  = IW + NCW;
  localparam int unsigned SQ_W   = 2 * IW + NCW;
  localparam int unsigned DIFF_W = SQ_W + NCW;
  localparam int unsigned NT_W   = NCW + ijm_pkg::THR_W;
  localparam int unsigned LIM_W  = 2 * NT_W;
  localparam int unsigned CMP_W  = (DIFF_W > LIM_W) ? DIFF_W : LIM_W;
  localparam int unsigned MQ_W   = SUM_W + ijm_pkg::FRAC_W;
  localparam int unsigned ME_W   = (MQ_W > ijm_pkg::OUT_W) ? MQ_W : ijm_pkg::OUT_W + 1;
  localparam int unsigned VQ_W   = DIFF_W + ijm_pkg::VAR_FRAC_W;
  localparam int unsigned VE_W   = (VQ_W > ijm_pkg::SQRT_IN_W) ? VQ_W
                                                                 : ijm_pkg::SQRT_IN_W + 1;
  localparam int unsigned SX_W   = ijm_pkg::SQRT_IN_W;
  localparam int unsigned SC_W   = $clog2(ijm_pkg::SQRT_OUT_W + 1);

  // interval capture
  logic [TW-1:0]    prev_q;
  logic             primed_q;
  logic [IW-1:0]    delta_q;
  logic             sat_q;
  logic [TW-1:0]    ts_diff;
  logic [EXT_W-1:0] ts_ext;
  logic             sat_in;

  assign ts_diff = arrival_time_us_i - prev_q;
  assign ts_ext  = EXT_W'(ts_diff);
  assign sat_in  = |ts_ext[EXT_W-1:IW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      primed_q <= 1'b0;
    end else if (cmd_i.accept) begin
      prev_q   <= arrival_time_us_i;
      primed_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      delta_q <= sat_in ? '1 : ts_ext[IW-1:0];
      sat_q   <= sat_in;
    end
  end

  // window storage
  logic [AW-1:0]  oldest_q;
  logic [NCW-1:0] fill_q;
  logic           full;
  logic [NCW:0]   slot_sum;
  logic [NCW:0]   slot_wrap;
  logic [IW-1:0]  rd_data;
  logic [IW-1:0]  old_val;

  assign full      = fill_q == NCW'(WINDOW);
  assign slot_sum  = (NCW + 1)'(oldest_q) + (NCW + 1)'(fill_q);
  assign slot_wrap = (slot_sum >= (NCW + 1)'(WINDOW)) ? slot_sum - (NCW + 1)'(WINDOW)
                                                        : slot_sum;
  assign old_val   = full ? rd_data : '0;

  ijm_ram #(
    .WIDTH (IW),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mul),
    .waddr_i (slot_wrap[AW-1:0]),
    .wdata_i (delta_q),
    .re_i    (cmd_i.rd_old),
    .raddr_i (oldest_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      fill_q   <= '0;
    end else if (cmd_i.mul) begin
      if (full) begin
        oldest_q <= (oldest_q == AW'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // running sums
  logic [IW-1:0]     old_q;
  logic [2*IW-1:0]   sq_new_q, sq_old_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sumsq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      old_q    <= old_val;
      sq_new_q <= delta_q * delta_q;
      sq_old_q <= old_val * old_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q   <= sum_q - SUM_W'(old_q) + SUM_W'(delta_q);
      sumsq_q <= sumsq_q - SQ_W'(sq_old_q) + SQ_W'(sq_new_q);
    end
  end

  // moment products
  logic [ijm_pkg::THR_W-1:0] thr_q;
  logic [DIFF_W-1:0]         prod_a_q, prod_b_q, diff_q;
  logic [NT_W-1:0]           nthr_q;
  logic [2*NCW-1:0]          n2_q;
  logic [LIM_W-1:0]          lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ijm_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      prod_a_q <= DIFF_W'(sumsq_q * fill_q);
      prod_b_q <= DIFF_W'(sum_q * sum_q);
      nthr_q   <= NT_W'(fill_q * thr_q);
      n2_q     <= fill_q * fill_q;
    end
    if (cmd_i.diff) begin
      diff_q <= prod_a_q - prod_b_q;
      lim_q  <= nthr_q * nthr_q;
    end
  end

  // dividers: mean = (sum << 8) / n, var16 = (diff << 16) / n^2
  logic             mdiv_busy, vdiv_busy;
  logic [MQ_W-1:0]  mean_quo;
  logic [VQ_W-1:0]  var_quo;
  logic [ME_W-1:0]  mean_ext;
  logic [VE_W-1:0]  var_ext;

  ijm_divider #(
    .NUM_W (MQ_W),
    .DEN_W (NCW)
  ) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({sum_q, {ijm_pkg::FRAC_W{1'b0}}}),
    .den_i   (fill_q),
    .busy_o  (mdiv_busy),
    .quo_o   (mean_quo)
  );

  ijm_divider #(
    .NUM_W (VQ_W),
    .DEN_W (2 * NCW)
  ) u_var_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({diff_q, {ijm_pkg::VAR_FRAC_W{1'b0}}}),
    .den_i   (n2_q),
    .busy_o  (vdiv_busy),
    .quo_o   (var_quo)
  );

  assign mean_ext = ME_W'(mean_quo);
  assign var_ext  = VE_W'(var_quo);

  // bit-pair square root, one result bit per cycle
  logic [SX_W-1:0] sq_x_q, sq_r_q, sq_bit_q, sq_try;
  logic [SC_W-1:0] sq_cnt_q;
  logic            jit_sat_q;

  assign sq_try = sq_r_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      sq_cnt_q <= SC_W'(ijm_pkg::SQRT_OUT_W);
    end else if (sq_cnt_q != '0) begin
      sq_cnt_q <= sq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sq_x_q    <= var_ext[SX_W-1:0];
      sq_r_q    <= '0;
      sq_bit_q  <= SX_W'(1) << (SX_W - 2);
      jit_sat_q <= |var_ext[VE_W-1:SX_W];
    end else if (sq_cnt_q != '0) begin
      if (sq_x_q >= sq_try) begin
        sq_x_q <= sq_x_q - sq_try;
        sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_interval_q8_o   <= (|mean_ext[ME_W-1:ijm_pkg::OUT_W]) ? '1
                              : mean_ext[ijm_pkg::OUT_W-1:0];
      jitter_q8_o          <= jit_sat_q ? '1 : sq_r_q[ijm_pkg::OUT_W-1:0];
      jitter_exceeded_o    <= CMP_W'(diff_q) > CMP_W'(lim_q);
      samples_in_window_o  <= ijm_pkg::SAMPLES_W'(fill_q);
      interval_saturated_o <= sat_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.primed    = primed_q;
  assign status_o.result_ok = fill_q >= NCW'(2);
  assign status_o.div_busy  = mdiv_busy || vdiv_busy;
  assign status_o.sqrt_busy = sq_cnt_q != '0;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// File: rtl/core/ijm_checker.sv
// Port-level checks of the interval jitter monitor, bound to the top level.
// Depends on ijm_pkg and interval_jitter_monitor_assert.svh.
`timescale 1ns / 1ps
`include "interval_jitter_monitor_assert.svh"

module ijm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ijm_pkg::OUT_W-1:0]     mean_interval_q8_o,
  input logic [ijm_pkg::OUT_W-1:0]     jitter_q8_o,
  input logic                          jitter_exceeded_o,
  input logic [ijm_pkg::SAMPLES_W-1:0] samples_in_window_o,
  input logic                          interval_saturated_o
);

  `IJM_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  `IJM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_interval_q8_o) && $stable(jitter_q8_o) && $stable(samples_in_window_o))

  `IJM_ASSERT(a_two_samples, clk_i, rst_ni, out_valid_o |-> samples_in_window_o >= ijm_pkg::SAMPLES_W'(2))

  `IJM_ASSERT(a_flag_needs_jitter, clk_i, rst_ni, out_valid_o && jitter_exceeded_o |-> jitter_q8_o != '0)

  `IJM_ASSERT(a_clamp_mean, clk_i, rst_ni, out_valid_o && interval_saturated_o |-> mean_interval_q8_o != '0)

endmodule

bind interval_jitter_monitor ijm_checker u_ijm_checker (.*);

// File: verif/tb_interval_jitter_monitor.sv
// Self-checking testbench for interval_jitter_monitor: timestamps in, windowed mean and
// jitter out, compared against an in-bench predictor. Depends on ijm_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_interval_jitter_monitor;

  localparam int unsigned WIN      = 100;
  localparam int unsigned IV_W     = 24;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned WD_LIMIT = 20000;  // quiet cycles before giving up

  typedef struct {
    logic [ijm_pkg::OUT_W-1:0]     mean;
    logic [ijm_pkg::OUT_W-1:0]     jitter;
    logic                          exceeded;
    logic [ijm_pkg::SAMPLES_W-1:0] samples;
    logic                          saturated;
  } jitter_result_t;

  // Tracks the interval window and queues the result each timestamp should produce.
  class jitter_scoreboard;
    bit [TS_W-1:0]          last_arrival;
    bit                     have_arrival;
    bit [IV_W-1:0]          intervals[WIN];
    int unsigned            head;
    int unsigned            fill;
    bit [63:0]              sum;
    bit [63:0]              sum_sq;
    bit [ijm_pkg::THR_W-1:0] threshold;
    jitter_result_t         pending[$];
    int unsigned            errors;

    function new();
      threshold = ijm_pkg::THR_RESET;
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] x);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_arrival(bit [TS_W-1:0] ts);
      bit [TS_W-1:0]  span;
      bit [63:0]      iv;
      bit [63:0]      n;
      bit [63:0]      mean;
      bit [127:0]     diff;
      bit [127:0]     sq_sum;
      bit [127:0]     nn;
      bit [127:0]     quo;
      bit [127:0]     rem;
      bit [127:0]     lim;
      bit [63:0]      var16;
      jitter_result_t r;
      if (!have_arrival) begin
        have_arrival = 1;
        last_arrival = ts;
        return;
      end
      span = ts - last_arrival;  // wraps at the timestamp width
      last_arrival = ts;
      r.saturated = span > {IV_W{1'b1}};
      iv = r.saturated ? 64'({IV_W{1'b1}}) : 64'(span);
      if (fill < WIN) begin
        intervals[(head + fill) % WIN] = iv[IV_W-1:0];
        fill++;
      end else begin
        sum -= intervals[head];
        sum_sq -= intervals[head] * intervals[head];
        intervals[head] = iv[IV_W-1:0];
        head = (head + 1) % WIN;
      end
      sum += iv;
      sum_sq += iv * iv;
      if (fill < 2) return;
      n = 64'(fill);
      mean = (sum << 8) / n;
      r.mean = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
      // n^2 * variance, exact
      sq_sum = sum_sq;
      diff = sq_sum * n;
      sq_sum = sum;
      diff = diff - sq_sum * sq_sum;
      nn = n * n;
      quo = diff / nn;
      rem = diff % nn;
      if (quo >= (128'd1 << 48)) begin
        r.jitter = 32'hFFFF_FFFF;
      end else begin
        var16 = (quo[63:0] << 16) + ((rem[63:0] << 16) / nn[63:0]);
        var16 = floor_sqrt(var16);
        r.jitter = (var16 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : var16[31:0];
      end
      lim = n * threshold;
      lim = lim * lim;
      r.exceeded = diff > lim;
      r.samples = n[ijm_pkg::SAMPLES_W-1:0];
      pending = {pending, r};
    endfunction

    function void check_result(jitter_result_t act);
      jitter_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result mean=%h jitter=%h", $time, act.mean, act.jitter);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.mean !== exp.mean) begin
        $display("%0t: mean exp %h act %h", $time, exp.mean, act.mean);
        errors++;
      end
      if (act.jitter !== exp.jitter) begin
        $display("%0t: jitter exp %h act %h", $time, exp.jitter, act.jitter);
        errors++;
      end
      if (act.exceeded !== exp.exceeded) begin
        $display("%0t: exceeded exp %b act %b", $time, exp.exceeded, act.exceeded);
        errors++;
      end
      if (act.samples !== exp.samples) begin
        $display("%0t: samples exp %0d act %0d", $time, exp.samples, act.samples);
        errors++;
      end
      if (act.saturated !== exp.saturated) begin
        $display("%0t: saturated exp %b act %b", $time, exp.saturated, act.saturated);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic                          in_valid_i = 0;
  logic                          in_ready_o;
  logic [TS_W-1:0]               arrival_time_us_i = '0;
  logic                          cfg_valid_i = 0;
  logic                          cfg_ready_o;
  logic [ijm_pkg::THR_W-1:0]     cfg_data_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 0;
  logic [ijm_pkg::OUT_W-1:0]     mean_interval_q8_o;
  logic [ijm_pkg::OUT_W-1:0]     jitter_q8_o;
  logic                          jitter_exceeded_o;
  logic [ijm_pkg::SAMPLES_W-1:0] samples_in_window_o;
  logic                          interval_saturated_o;

  jitter_scoreboard sb = new();

  int unsigned send_idle_pct;   // sender gap odds per cycle, percent
  int unsigned recv_stall_pct;  // receiver stall odds per cycle, percent
  bit          hold_req;        // asks the receiver for one long hold-off
  bit          hold_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit [TS_W-1:0] cur_ts;        // last timestamp sent
  int unsigned   base_gap;      // nominal packet spacing for the current phase
  int unsigned   spread;        // jitter range added on top of base_gap

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  interval_jitter_monitor DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .arrival_time_us_i   (arrival_time_us_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .mean_interval_q8_o  (mean_interval_q8_o),
    .jitter_q8_o         (jitter_q8_o),
    .jitter_exceeded_o   (jitter_exceeded_o),
    .samples_in_window_o (samples_in_window_o),
    .interval_saturated_o(interval_saturated_o)
  );

  // Result side: check each accepted transaction, then pick next cycle's ready.
  // A requested hold-off is counted here so it runs regardless of the sender.
  always @(posedge clk_i) begin
    jitter_result_t act;
    if (out_valid_o && out_ready_i) begin
      act.mean      = mean_interval_q8_o;
      act.jitter    = jitter_q8_o;
      act.exceeded  = jitter_exceeded_o;
      act.samples   = samples_in_window_o;
      act.saturated = interval_saturated_o;
      sb.check_result(act);
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= 3000;
      out_ready_i <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One timestamp transaction; valid stays up into the next call when no gap is drawn.
  task automatic send_arrival(bit [TS_W-1:0] ts);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1;
    arrival_time_us_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_arrival(ts);
    cur_ts = ts;
  endtask

  task automatic write_threshold(bit [ijm_pkg::THR_W-1:0] thr);
    cfg_valid_i <= 1;
    cfg_data_i <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.threshold = thr;
  endtask

  // Let results drain, then give no-result items time to retire.
  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Mostly steady traffic around base_gap; some wild jumps and odd cases.
  function automatic bit [TS_W-1:0] next_arrival();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return cur_ts + base_gap + $urandom_range(spread);
    if (pick < 88) return $urandom();
    if (pick < 94) return cur_ts + 32'h0100_0000 + $urandom_range(32'h00FF_FFFF);
    if (pick < 97) return cur_ts;                  // zero interval
    return cur_ts - $urandom_range(3) - 1;         // wraps to a huge interval
  endfunction

  task automatic run_phase(int unsigned count, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    base_gap = $urandom_range(1, 20000);
    spread = $urandom_range(1) ? $urandom_range(50) : $urandom_range(40000);
    repeat (count) send_arrival(next_arrival());
    wait_idle();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: priming, one interval, wrap, clamp boundary, bit patterns,
    // constant spacing and alternating spacing under the reset threshold.
    send_arrival(32'hFFFF_FFF0);  // primes only
    send_arrival(32'h0000_0010);  // wrapped, single interval: no result
    send_arrival(32'h0000_0010);  // zero interval, first result
    send_arrival(32'h0000_0000);  // wraps to a clamped interval
    send_arrival(32'h00FF_FFFF);  // exactly the largest unclamped interval
    send_arrival(32'h0200_0000);  // clamped
    send_arrival(32'hAAAA_AAAA);
    send_arrival(32'h5555_5555);
    send_arrival(32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_arrival(cur_ts + 1000);
    for (int i = 0; i < 6; i++) send_arrival(cur_ts + 1000 + (i[0] ? 600 : 0));
    wait_idle();

    // Random phases over several thresholds, extremes included.
    write_threshold('0);
    run_phase(150, 0, 0);
    write_threshold('1);
    run_phase(150, 63, 0);
    write_threshold(ijm_pkg::THR_W'($urandom_range(5000)));
    run_phase(150, 0, 63);
    write_threshold(ijm_pkg::THR_RESET);
    run_phase(120, 14, 14);

    // Back-pressure: receiver holds off while the sender keeps offering.
    write_threshold(ijm_pkg::THR_W'($urandom_range(24'hFF_FFFF)));
    send_idle_pct = 0;
    recv_stall_pct = 20;
    hold_req = 1;
    repeat (100) send_arrival(next_arrival());
    wait_idle();
    @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ijm_pkg.sv
rtl/core/ijm_ram.sv
rtl/core/ijm_divider.sv
rtl/core/ijm_ctrl.sv
rtl/core/ijm_datapath.sv
rtl/core/interval_jitter_monitor.sv
rtl/core/ijm_checker.sv
verif/tb_interval_jitter_monitor.sv
